// ===== src/mde_pkg.sv =====
// ----------------------------------------------------------------------------
// mde_pkg
// Shared constants for the integer matrix determinant engine.
// ----------------------------------------------------------------------------
package mde_pkg;

    localparam int MAX_ORDER_DEF    = 4;
    localparam int ELEMENT_BITS_DEF = 12;
    localparam int DET_BITS         = 50;
    localparam int DET_LO_BITS      = 25;
    localparam int DET_HI_BITS      = DET_BITS - DET_LO_BITS;
    localparam int COUNT_BITS       = 3;
    localparam int CFG_INDEX_BITS   = 1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_COUNT    = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COLUMN_COUNT = 1'd1;

    localparam logic [COUNT_BITS-1:0] COUNT_RESET = 3'd4;

endpackage

// ===== src/mde_front.sv =====
// ----------------------------------------------------------------------------
// mde_front
// Element loader: holds the size registers, tracks the load position and
// tags each element with its store address and end-of-matrix flags.
// ----------------------------------------------------------------------------
module mde_front #(
    parameter int MAX_ORDER    = mde_pkg::MAX_ORDER_DEF,
    parameter int ELEMENT_BITS = mde_pkg::ELEMENT_BITS_DEF,
    parameter int AW           = 4,
    parameter int OW           = 3
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mde_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [mde_pkg::COUNT_BITS-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [ELEMENT_BITS-1:0]      i_element_value,
    input  logic                                i_q_full,
    output logic                                o_q_push,
    output logic [ELEMENT_BITS-1:0]             o_q_value,
    output logic [AW-1:0]                       o_q_addr,
    output logic [OW-1:0]                       o_q_order,
    output logic                                o_q_last,
    output logic                                o_q_not_square
);

    logic [mde_pkg::COUNT_BITS-1:0] r_rows;
    logic [mde_pkg::COUNT_BITS-1:0] r_cols;
    logic [AW-1:0]                  r_pos;
    logic [OW-1:0]                  rows_c;
    logic [OW-1:0]                  cols_c;
    logic                           last;
    logic                           accept;

    always_comb begin
        if (r_rows == '0) begin
            rows_c = OW'(1);
        end else if (int'(r_rows) > MAX_ORDER) begin
            rows_c = OW'(MAX_ORDER);
        end else begin
            rows_c = OW'(r_rows);
        end
        if (r_cols == '0) begin
            cols_c = OW'(1);
        end else if (int'(r_cols) > MAX_ORDER) begin
            cols_c = OW'(MAX_ORDER);
        end else begin
            cols_c = OW'(r_cols);
        end
    end

    assign last           = (int'(r_pos) + 1) == (int'(rows_c) * int'(cols_c));
    assign accept         = i_in_valid && !i_q_full;
    assign o_in_stall     = i_q_full;
    assign o_cfg_ready    = 1'b1;
    assign o_q_push       = accept;
    assign o_q_value      = i_element_value;
    assign o_q_addr       = r_pos;
    assign o_q_order      = rows_c;
    assign o_q_last       = last;
    assign o_q_not_square = rows_c != cols_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= mde_pkg::COUNT_RESET;
            r_cols <= mde_pkg::COUNT_RESET;
            r_pos  <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == mde_pkg::REG_ROW_COUNT) begin
                r_rows <= i_cfg_data;
            end else begin
                r_cols <= i_cfg_data;
            end
            r_pos <= '0;
        end else if (accept) begin
            r_pos <= last ? '0 : r_pos + AW'(1);
        end
    end

endmodule

// ===== src/mde_queue.sv =====
// ----------------------------------------------------------------------------
// mde_queue
// Two-entry queue between the loader and the elimination engine.
// ----------------------------------------------------------------------------
module mde_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_count;

    assign o_full  = r_count == 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

// ===== src/mde_back.sv =====
// ----------------------------------------------------------------------------
// mde_back
// Elimination engine: stores elements, then builds minors over column
// subsets with two multipliers (low and high halves of a minor), and holds the result beat.
// ----------------------------------------------------------------------------
module mde_back #(
    parameter int MAX_ORDER    = mde_pkg::MAX_ORDER_DEF,
    parameter int ELEMENT_BITS = mde_pkg::ELEMENT_BITS_DEF,
    parameter int AW           = 4,
    parameter int OW           = 3
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_q_valid,
    output logic                                  o_q_pop,
    input  logic [ELEMENT_BITS-1:0]               i_q_value,
    input  logic [AW-1:0]                         i_q_addr,
    input  logic [OW-1:0]                         i_q_order,
    input  logic                                  i_q_last,
    input  logic                                  i_q_not_square,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [mde_pkg::DET_BITS-1:0]   o_determinant,
    output logic                                  o_not_square
);

    localparam int DB   = mde_pkg::DET_BITS;
    localparam int LB   = mde_pkg::DET_LO_BITS;
    localparam int HB   = mde_pkg::DET_HI_BITS;
    localparam int CW   = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int SD   = 2 ** MAX_ORDER;
    localparam int PW   = ELEMENT_BITS + LB + 1;
    localparam int QW   = ELEMENT_BITS + HB + 1;
    localparam int EMD  = MAX_ORDER * MAX_ORDER;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INIT = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_MLO  = 3'd3;
    localparam logic [2:0] S_MHI  = 3'd4;
    localparam logic [2:0] S_ACC  = 3'd5;
    localparam logic [2:0] S_NEXT = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]                     r_state;
    logic [ELEMENT_BITS-1:0]        r_emem [EMD];
    logic [DB-1:0]                  r_dmem [SD];
    logic signed [ELEMENT_BITS-1:0] r_e_q;
    logic [DB-1:0]                  r_d_q;
    logic [OW-1:0]                  r_n;
    logic [MAX_ORDER-1:0]           r_set;
    logic [CW-1:0]                  r_col;
    logic                           r_j;
    logic [DB-1:0]                  r_acc;
    logic [DB-1:0]                  r_plo;
    logic [LB-1:0]                  r_phi;
    logic [DB-1:0]                  r_res;
    logic                           r_res_ns;
    logic                           r_out_valid;
    logic [DB-1:0]                  r_out_det;
    logic                           r_out_ns;

    logic [MAX_ORDER-1:0]           full_set;
    logic [MAX_ORDER-1:0]           sub_set;
    logic [OW-1:0]                  k;
    logic [AW-1:0]                  e_addr;
    logic                           col_last;
    logic                           neg;
    logic signed [PW-1:0]           plo_w;
    logic signed [QW-1:0]           phi_w;
    logic [DB-1:0]                  term;
    logic [DB-1:0]                  acc_new;
    logic                           pop;
    logic                           d_we;
    logic [MAX_ORDER-1:0]           d_waddr;
    logic [DB-1:0]                  d_wdata;

    always_comb begin
        full_set = '0;
        k        = '0;
        for (int i = 0; i < MAX_ORDER; i++) begin
            full_set[i] = i < int'(r_n);
            k           = k + OW'(r_set[i]);
        end
    end

    assign sub_set  = r_set & ~(MAX_ORDER'(1) << r_col);
    assign e_addr   = AW'((int'(k) - 1) * int'(r_n) + int'(r_col));
    assign col_last = int'(r_col) == int'(r_n) - 1;
    assign neg      = (k[0] ^ 1'b1) ^ r_j;
    assign plo_w    = r_e_q * $signed({1'b0, r_d_q[LB-1:0]});
    assign phi_w    = r_e_q * $signed({1'b0, r_d_q[DB-1:LB]});
    assign term     = r_plo + {r_phi, {(DB-LB){1'b0}}};
    assign acc_new  = neg ? r_acc - term : r_acc + term;
    assign pop      = (r_state == S_IDLE) && i_q_valid;
    assign o_q_pop  = pop;

    assign d_we    = (r_state == S_INIT) || ((r_state == S_NEXT) && col_last);
    assign d_waddr = (r_state == S_INIT) ? '0 : r_set;
    assign d_wdata = (r_state == S_INIT) ? DB'(1) : r_acc;

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_emem[i_q_addr] <= i_q_value;
        end
        r_e_q <= r_emem[e_addr];
    end

    always_ff @(posedge i_clk) begin
        if (d_we) begin
            r_dmem[d_waddr] <= d_wdata;
        end
        r_d_q <= r_dmem[sub_set];
    end

    always_ff @(posedge i_clk) begin
        r_plo <= DB'(plo_w);
        r_phi <= phi_w[LB-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (pop && i_q_last) begin
                        r_n <= i_q_order;
                        if (i_q_not_square) begin
                            r_res    <= '0;
                            r_res_ns <= 1'b1;
                            r_state  <= S_OUT;
                        end else begin
                            r_state <= S_INIT;
                        end
                    end
                end
                S_INIT: begin
                    r_set   <= MAX_ORDER'(1);
                    r_col   <= '0;
                    r_j     <= 1'b0;
                    r_acc   <= '0;
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_state <= r_set[r_col] ? S_MLO : S_NEXT;
                end
                S_MLO: begin
                    r_state <= S_MHI;
                end
                S_MHI: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc   <= acc_new;
                    r_j     <= ~r_j;
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    if (!col_last) begin
                        r_col   <= r_col + CW'(1);
                        r_state <= S_READ;
                    end else if (r_set == full_set) begin
                        r_res    <= r_acc;
                        r_res_ns <= 1'b0;
                        r_state  <= S_OUT;
                    end else begin
                        r_set   <= r_set + MAX_ORDER'(1);
                        r_col   <= '0;
                        r_j     <= 1'b0;
                        r_acc   <= '0;
                        r_state <= S_READ;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_det   <= r_res;
                        r_out_ns    <= r_res_ns;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_determinant = r_out_det;
    assign o_not_square  = r_out_ns;

endmodule

// ===== src/matrix_determinant_elimination.sv =====
// ----------------------------------------------------------------------------
// matrix_determinant_elimination
// Exact integer determinant of a loaded matrix of up to MAX_ORDER rows.
// ----------------------------------------------------------------------------
// Usage:
//   Write row_count (index 0) and column_count (index 1) on the cfg channel
//   while idle; each write restarts loading. Counts of 0 act as 1 and counts
//   above MAX_ORDER act as MAX_ORDER.
//   Send rows*cols elements, row-major, on the input channel, one beat per
//   cycle while the element queue has room. After the last element one
//   result beat carries the determinant (low 50 bits) and not_square.
//   A non-square matrix gives 0 with not_square set, right after its last
//   element. For a square matrix of order n the engine walks all column
//   subsets with two multipliers, one for each half of a stored minor.
//   Loading of the next matrix continues into the two-entry queue while the
//   engine works; one matrix is computed at a time.
//   Reset returns both counts to 4 and the load position to 0.
//   A stalled result beat holds in the output register; the engine holds
//   its next result until that register frees.
// ----------------------------------------------------------------------------
module matrix_determinant_elimination #(
    parameter int MAX_ORDER    = mde_pkg::MAX_ORDER_DEF,
    parameter int ELEMENT_BITS = mde_pkg::ELEMENT_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [mde_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [mde_pkg::COUNT_BITS-1:0]       i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [ELEMENT_BITS-1:0]       i_element_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [mde_pkg::DET_BITS-1:0]  o_determinant,
    output logic                                 o_not_square
);

    localparam int AW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER * MAX_ORDER) : 1;
    localparam int OW = $clog2(MAX_ORDER + 1);
    localparam int QW = ELEMENT_BITS + AW + OW + 2;

    logic                    q_full;
    logic                    q_push;
    logic [ELEMENT_BITS-1:0] f_value;
    logic [AW-1:0]           f_addr;
    logic [OW-1:0]           f_order;
    logic                    f_last;
    logic                    f_ns;
    logic                    q_valid;
    logic                    q_pop;
    logic [QW-1:0]           q_out;

    mde_front #(
        .MAX_ORDER    (MAX_ORDER),
        .ELEMENT_BITS (ELEMENT_BITS),
        .AW           (AW),
        .OW           (OW)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_element_value (i_element_value),
        .i_q_full        (q_full),
        .o_q_push        (q_push),
        .o_q_value       (f_value),
        .o_q_addr        (f_addr),
        .o_q_order       (f_order),
        .o_q_last        (f_last),
        .o_q_not_square  (f_ns)
    );

    mde_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({f_ns, f_last, f_order, f_addr, f_value}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    mde_back #(
        .MAX_ORDER    (MAX_ORDER),
        .ELEMENT_BITS (ELEMENT_BITS),
        .AW           (AW),
        .OW           (OW)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .o_q_pop        (q_pop),
        .i_q_value      (q_out[ELEMENT_BITS-1:0]),
        .i_q_addr       (q_out[ELEMENT_BITS +: AW]),
        .i_q_order      (q_out[ELEMENT_BITS+AW +: OW]),
        .i_q_last       (q_out[QW-2]),
        .i_q_not_square (q_out[QW-1]),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_determinant  (o_determinant),
        .o_not_square   (o_not_square)
    );

endmodule
